>>> rtl/assert_macros.svh
// Assertion macros shared by the finder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the following cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/dfnf_pkg.sv
// Types, constants and helpers of the downslope neighbor finder.
package dfnf_pkg;

  localparam int unsigned MAX_ROWS  = 256;
  localparam int unsigned MAX_COLS  = 256;
  localparam int unsigned ELEV_BITS = 32;

  localparam int unsigned ROW_W     = $clog2(MAX_ROWS);
  localparam int unsigned COL_W     = $clog2(MAX_COLS);
  localparam int unsigned ADDR_W    = ROW_W + COL_W;
  localparam int unsigned CELLS     = MAX_ROWS * MAX_COLS;
  localparam int unsigned ELEV_IN_W = 32;
  localparam int unsigned DROP_W    = 32;
  localparam int unsigned MASK_W    = 4;
  localparam int unsigned WORD_W    = MASK_W + ELEV_BITS;
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned STS_W     = 3;
  localparam int unsigned NBR_CNT   = 4;
  localparam int unsigned CNT_W     = $clog2(NBR_CNT + 1);
  localparam int unsigned PTR_W     = $clog2(NBR_CNT);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'd1;

  // Request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Result status codes
  localparam logic [STS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STS_W-1:0] STS_OFF_SOUTH = 3'd1;
  localparam logic [STS_W-1:0] STS_OFF_NORTH = 3'd2;
  localparam logic [STS_W-1:0] STS_OFF_WEST  = 3'd3;
  localparam logic [STS_W-1:0] STS_OFF_EAST  = 3'd4;

  // Neighbor visiting order
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  // Parent mask bits
  localparam logic [MASK_W-1:0] PBIT_S = 4'b0001;
  localparam logic [MASK_W-1:0] PBIT_E = 4'b0010;
  localparam logic [MASK_W-1:0] PBIT_N = 4'b0100;
  localparam logic [MASK_W-1:0] PBIT_W = 4'b1000;

  typedef struct packed {
    logic       wr;        // write the cell at the request coordinates
    logic       ld_query;  // latch query coordinates, read the center cell
    logic       ld_err;    // latch an off-grid status
    logic       ld_ctr;    // latch center elevation and mask
    logic       rd_nbr;    // read one neighbor
    logic [1:0] rd_dir;
    logic       cmp;       // compare the neighbor read last cycle
    logic [1:0] cmp_dir;
    logic       emit;      // load the next result into the output register
  } cmd_t;

  typedef struct packed {
    logic q_err;      // request coordinates put a neighbor off the grid
    logic out_free;   // output register can take a result this cycle
    logic emit_last;  // result at the head of the buffer ends the query
  } sts_t;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic              neighbor_valid;
    logic [ROW_W-1:0]  neighbor_row;
    logic [COL_W-1:0]  neighbor_col;
    logic [DROP_W-1:0] elevation_drop;
    logic [CNT_W-1:0]  neighbor_total;
    logic              last;
  } rsp_t;

  function automatic logic [MASK_W-1:0] dir_pbit(input logic [1:0] dir);
    logic [MASK_W-1:0] b;
    unique case (dir)
      DIR_N:   b = PBIT_N;
      DIR_E:   b = PBIT_E;
      DIR_S:   b = PBIT_S;
      default: b = PBIT_W;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/dfnf_if.sv
// Request and result channel interfaces of the downslope neighbor finder.
interface dfnf_req_if import dfnf_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [ROW_W-1:0]            cell_row;
  logic [COL_W-1:0]            cell_col;
  logic signed [ELEV_IN_W-1:0] elevation;
  logic [MASK_W-1:0]           parent_mask;

  modport source (output valid, req_type, cell_row, cell_col, elevation, parent_mask,
                  input ready);
  modport sink (input valid, req_type, cell_row, cell_col, elevation, parent_mask,
                output ready);
endinterface

interface dfnf_rsp_if import dfnf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STS_W-1:0]  status;
  logic              neighbor_valid;
  logic [ROW_W-1:0]  neighbor_row;
  logic [COL_W-1:0]  neighbor_col;
  logic [DROP_W-1:0] elevation_drop;
  logic [CNT_W-1:0]  neighbor_total;
  logic              last;

  modport source (output valid, status, neighbor_valid, neighbor_row, neighbor_col,
                  elevation_drop, neighbor_total, last, input ready);
  modport sink (input valid, status, neighbor_valid, neighbor_row, neighbor_col,
                elevation_drop, neighbor_total, last, output ready);
endinterface

>>> rtl/downslope_four_neighbor_finder_unit.sv
// Top level of the downslope four-neighbor finder.
// Usage:
//   req_i carries requests. A write request (req_type 0) stores elevation and
//   parent_mask at cell_row/cell_col and returns nothing. A query
//   request (req_type 1) looks at the north, east, south and west neighbors of
//   the named cell and returns one to four results on rsp_o; the final result
//   of a query has last set.
//   The configuration port (cfg_we_i, cfg_idx_i, cfg_wdata_i) sets num_rows
//   (index 0) and num_cols (index 1); write it only while the block is idle.
// Sequencing:
//   A write is done when it is accepted. An off-grid query goes straight to loading
//   its result. A normal query reads the center and four neighbors in turn through
//   the single read port, then loads its N results (1 to 4) one by one; no request
//   is taken until the last result of the query is loaded.
// Reset:
//   Clears the state machine, the output register and sets both grid sizes to
//   256. The grid memory is not cleared; read only cells that were written.
// Stall:
//   A result waits in the output register while rsp_o.ready is low; the scan
//   holds before loading the next result, and no request is taken meanwhile.
module downslope_four_neighbor_finder_unit import dfnf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  dfnf_req_if.sink             req_i,
  dfnf_rsp_if.source           rsp_o
);

  cmd_t cmd;
  sts_t sts;
  rsp_t rsp;
  logic rsp_valid;

  // Sequencer: owns the request handshake and steps the scan
  dfnf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Datapath: grid memory, compare, result buffer and output register
  dfnf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cell_row_i    (req_i.cell_row),
    .cell_col_i    (req_i.cell_col),
    .elevation_i   (req_i.elevation),
    .parent_mask_i (req_i.parent_mask),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .rsp_valid_o   (rsp_valid),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_o         (rsp)
  );

  // Unpack the result onto the channel
  assign rsp_o.valid          = rsp_valid;
  assign rsp_o.status         = rsp.status;
  assign rsp_o.neighbor_valid = rsp.neighbor_valid;
  assign rsp_o.neighbor_row   = rsp.neighbor_row;
  assign rsp_o.neighbor_col   = rsp.neighbor_col;
  assign rsp_o.elevation_drop = rsp.elevation_drop;
  assign rsp_o.neighbor_total = rsp.neighbor_total;
  assign rsp_o.last           = rsp.last;

endmodule

>>> rtl/dfnf_ctrl.sv
// Sequencing state machine of the downslope neighbor finder.
`include "assert_macros.svh"

module dfnf_ctrl import dfnf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic req_type_i,
  output logic req_ready_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CENTER = 2'd1;
  localparam logic [1:0] S_NBR    = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state_q, state_d;
  logic [1:0] dir_q, dir_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    dir_d       = dir_q;
    req_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          if (req_type_i == REQ_WRITE) begin
            cmd_o.wr = 1'b1;
          end else if (sts_i.q_err) begin
            cmd_o.ld_err = 1'b1;
            state_d      = S_EMIT;
          end else begin
            cmd_o.ld_query = 1'b1;
            state_d        = S_CENTER;
          end
        end
      end
      S_CENTER: begin
        cmd_o.ld_ctr = 1'b1;
        cmd_o.rd_nbr = 1'b1;
        cmd_o.rd_dir = DIR_N;
        dir_d        = DIR_N;
        state_d      = S_NBR;
      end
      S_NBR: begin
        cmd_o.cmp     = 1'b1;
        cmd_o.cmp_dir = dir_q;
        if (dir_q == DIR_W) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.rd_nbr = 1'b1;
          cmd_o.rd_dir = dir_q + 2'd1;
          dir_d        = dir_q + 2'd1;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dir_q   <= DIR_N;
    end else begin
      state_q <= state_d;
      dir_q   <= dir_d;
    end
  end

  `ASSERT_NEXT(a_query_leaves_idle, req_ready_o && req_valid_i && req_type_i == REQ_QUERY, state_q != S_IDLE, "query accepted but controller stayed idle")
  `ASSERT_NEXT(a_scan_ends_in_emit, state_q == S_NBR && dir_q == DIR_W, state_q == S_EMIT, "neighbor scan did not end in emit")
  `ASSERT_IMPL(a_emit_needs_room, cmd_o.emit, sts_i.out_free, "result loaded into a busy output register")

endmodule

>>> rtl/dfnf_dp.sv
// Grid memory, neighbor compare, result buffer and output register.
`include "assert_macros.svh"

module dfnf_dp import dfnf_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]            cfg_wdata_i,
  input  logic [ROW_W-1:0]            cell_row_i,
  input  logic [COL_W-1:0]            cell_col_i,
  input  logic signed [ELEV_IN_W-1:0] elevation_i,
  input  logic [MASK_W-1:0]           parent_mask_i,
  input  cmd_t                        cmd_i,
  output sts_t                        sts_o,
  output logic                        rsp_valid_o,
  input  logic                        rsp_ready_i,
  output rsp_t                        rsp_o
);

  logic [CFG_W-1:0] rows_q, cols_q;
  logic [CFG_W-1:0] rows_eff, cols_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_W'(MAX_ROWS);
      cols_q <= CFG_W'(MAX_COLS);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_ROWS: rows_q <= cfg_wdata_i;
        default:      cols_q <= cfg_wdata_i;
      endcase
    end
  end

  assign rows_eff = (rows_q > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_q;
  assign cols_eff = (cols_q > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : cols_q;

  // Off-grid check on the incoming request, south first
  logic [STS_W-1:0] err_code;
  always_comb begin
    priority if (cell_row_i == '0) begin
      err_code = STS_OFF_SOUTH;
    end else if (CFG_W'(cell_row_i) + CFG_W'(1) >= rows_eff) begin
      err_code = STS_OFF_NORTH;
    end else if (cell_col_i == '0) begin
      err_code = STS_OFF_WEST;
    end else if (CFG_W'(cell_col_i) + CFG_W'(1) >= cols_eff) begin
      err_code = STS_OFF_EAST;
    end else begin
      err_code = STS_OK;
    end
  end
  assign sts_o.q_err = (err_code != STS_OK);

  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;

  function automatic logic [ADDR_W-1:0] nbr_addr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c,
                                                 input logic [1:0] dir);
    logic [ADDR_W-1:0] a;
    unique case (dir)
      DIR_N:   a = {r + ROW_W'(1), c};
      DIR_E:   a = {r, c + COL_W'(1)};
      DIR_S:   a = {r - ROW_W'(1), c};
      default: a = {r, c - COL_W'(1)};
    endcase
    return a;
  endfunction

  // Grid store: one write port, one registered read port
  logic [WORD_W-1:0] mem [CELLS];
  logic [WORD_W-1:0] rd_q;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;

  assign rd_en   = cmd_i.ld_query | cmd_i.rd_nbr;
  assign rd_addr = cmd_i.ld_query ? {cell_row_i, cell_col_i}
                                  : nbr_addr(row_q, col_q, cmd_i.rd_dir);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[{cell_row_i, cell_col_i}] <= {parent_mask_i, ELEV_BITS'(elevation_i)};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  logic [ELEV_BITS-1:0] ctr_elev_q;
  logic [MASK_W-1:0]    ctr_mask_q;
  logic [ELEV_BITS-1:0] nbr_elev;
  logic [ADDR_W-1:0]    cmp_addr;
  logic                 hit;

  assign nbr_elev = rd_q[ELEV_BITS-1:0];
  assign cmp_addr = nbr_addr(row_q, col_q, cmd_i.cmp_dir);
  assign hit      = cmd_i.cmp && ((ctr_mask_q & dir_pbit(cmd_i.cmp_dir)) == '0)
                    && ($signed(ctr_elev_q) > $signed(nbr_elev));

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_query) begin
      row_q <= cell_row_i;
      col_q <= cell_col_i;
    end
    if (cmd_i.ld_ctr) begin
      ctr_elev_q <= rd_q[ELEV_BITS-1:0];
      ctr_mask_q <= rd_q[WORD_W-1:ELEV_BITS];
    end
  end

  // Result buffer: filled during the scan, drained one result per emit
  logic [ROW_W-1:0]  buf_row_q  [NBR_CNT];
  logic [COL_W-1:0]  buf_col_q  [NBR_CNT];
  logic [DROP_W-1:0] buf_drop_q [NBR_CNT];
  logic [CNT_W-1:0]  cnt_q;
  logic [PTR_W-1:0]  ptr_q;
  logic [STS_W-1:0]  status_q;

  always_ff @(posedge clk_i) begin
    if (hit) begin
      buf_row_q[cnt_q[PTR_W-1:0]]  <= cmp_addr[ADDR_W-1:COL_W];
      buf_col_q[cnt_q[PTR_W-1:0]]  <= cmp_addr[COL_W-1:0];
      buf_drop_q[cnt_q[PTR_W-1:0]] <= DROP_W'(ctr_elev_q - nbr_elev);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ptr_q    <= '0;
      status_q <= STS_OK;
    end else if (cmd_i.ld_query || cmd_i.ld_err) begin
      cnt_q    <= '0;
      ptr_q    <= '0;
      status_q <= err_code;
    end else begin
      if (hit) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.emit) begin
        ptr_q <= ptr_q + PTR_W'(1);
      end
    end
  end

  rsp_t cur;
  always_comb begin
    cur = '0;
    if (cnt_q == '0) begin
      cur.status = status_q;
      cur.last   = 1'b1;
    end else begin
      cur.status         = STS_OK;
      cur.neighbor_valid = 1'b1;
      cur.neighbor_row   = buf_row_q[ptr_q];
      cur.neighbor_col   = buf_col_q[ptr_q];
      cur.elevation_drop = buf_drop_q[ptr_q];
      cur.neighbor_total = cnt_q;
      cur.last           = (CNT_W'(ptr_q) + CNT_W'(1) == cnt_q);
    end
  end
  assign sts_o.emit_last = cur.last;

  // Output register
  logic out_valid_q;
  rsp_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= cur;
    end
  end

  assign sts_o.out_free = !out_valid_q || rsp_ready_i;
  assign rsp_valid_o    = out_valid_q;
  assign rsp_o          = out_q;

  `ASSERT_RST(a_cnt_bounded, cnt_q <= CNT_W'(NBR_CNT), "neighbor count above four")
  `ASSERT_IMPL(a_found_is_ok, out_valid_q && out_q.neighbor_valid, out_q.status == STS_OK && out_q.neighbor_total != '0, "neighbor result with bad status or total")
  `ASSERT_IMPL(a_err_is_last, out_valid_q && out_q.status != STS_OK, out_q.last && !out_q.neighbor_valid, "off-grid result not final or marked valid")

endmodule

>>> tb/sv/tb.sv
// Testbench of the downslope four-neighbor finder: grid writes and neighbor queries checked result by result.
`timescale 1ns / 100ps

module tb;
  import dfnf_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  // Allow plenty of idle time after the last result before touching the size registers.
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned PHASE_ITEMS   = 56;
  localparam int unsigned RANDOM_PHASES = 6;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  dfnf_req_if req_bus ();
  dfnf_rsp_if rsp_bus ();

  downslope_four_neighbor_finder_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  // Shadow copy of the grid and the size registers, updated as requests are taken.
  logic [ELEV_BITS-1:0] grid_elev_m  [CELLS];
  logic [MASK_W-1:0]    grid_pmask_m [CELLS];
  bit                   grid_filled  [CELLS];
  int                   rows_in_use = MAX_ROWS;
  int                   cols_in_use = MAX_COLS;

  // Neighbor visiting order: north, east, south, west.
  int                   row_step   [4] = '{1, 0, -1, 0};
  int                   col_step   [4] = '{0, 1, 0, -1};
  logic [MASK_W-1:0]    parent_bit [4] = '{PBIT_N, PBIT_E, PBIT_S, PBIT_W};

  // Results still owed by the block, oldest first.
  rsp_t                 nbr_results_q [$];

  int unsigned          bad_results   = 0;
  int unsigned          requests_sent = 0;
  int unsigned          cycle_count   = 0;
  bit                   send_gaps_on  = 1'b1;
  bit                   rsp_gaps_on   = 1'b1;
  int unsigned          rsp_hold_len  = 0;
  logic [ROW_W-1:0]     last_row      = 1;
  logic [COL_W-1:0]     last_col      = 1;

  function automatic int unsigned cell_at(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
    return 32'({r, c});
  endfunction

  // Work out the results of one query against the shadow grid and queue them.
  function automatic void predict_query(input logic [ROW_W-1:0] row,
                                        input logic [COL_W-1:0] col);
    logic [ELEV_BITS-1:0] ctr_elev;
    logic [ELEV_BITS-1:0] nbr_elev;
    logic [MASK_W-1:0]    ctr_mask;
    rsp_t                 hits [$];
    rsp_t                 res;
    int                   nr;
    int                   nc;
    res      = '0;
    res.last = 1'b1;
    // Off-grid checks go south, north, west, east; the first one that trips wins.
    if (row == 0)                        res.status = STS_OFF_SOUTH;
    else if (int'(row) + 1 >= rows_in_use) res.status = STS_OFF_NORTH;
    else if (col == 0)                   res.status = STS_OFF_WEST;
    else if (int'(col) + 1 >= cols_in_use) res.status = STS_OFF_EAST;
    if (res.status != STS_OK) begin
      nbr_results_q.push_back(res);
      return;
    end
    ctr_elev = grid_elev_m[cell_at(row, col)];
    ctr_mask = grid_pmask_m[cell_at(row, col)];
    for (int d = 0; d < 4; d++) begin
      // Skip parents; keep only neighbors strictly lower than the center.
      if ((ctr_mask & parent_bit[d]) != '0) continue;
      nr       = int'(row) + row_step[d];
      nc       = int'(col) + col_step[d];
      nbr_elev = grid_elev_m[cell_at(nr[ROW_W-1:0], nc[COL_W-1:0])];
      if ($signed(ctr_elev) > $signed(nbr_elev)) begin
        res                = '0;
        res.status         = STS_OK;
        res.neighbor_valid = 1'b1;
        res.neighbor_row   = nr[ROW_W-1:0];
        res.neighbor_col   = nc[COL_W-1:0];
        res.elevation_drop = DROP_W'(ctr_elev - nbr_elev);
        hits.push_back(res);
      end
    end
    if (hits.size() == 0) begin
      // Nothing lower: one empty result closes the query.
      res      = '0;
      res.last = 1'b1;
      nbr_results_q.push_back(res);
      return;
    end
    foreach (hits[i]) begin
      hits[i].neighbor_total = CNT_W'(hits.size());
      hits[i].last           = (i == hits.size() - 1);
      nbr_results_q.push_back(hits[i]);
    end
  endfunction

  // Pick an elevation close to an anchor so that comparisons go both ways,
  // with the occasional equal, extreme or fully random value.
  function automatic logic [ELEV_BITS-1:0] elev_near(input logic [ELEV_BITS-1:0] anchor);
    int unsigned pick;
    pick = $urandom_range(0, 11);
    if (pick == 0) return $urandom();
    if (pick == 1) return anchor;
    if (pick == 2) return {1'b1, {(ELEV_BITS-1){1'b0}}};
    if (pick == 3) return {1'b0, {(ELEV_BITS-1){1'b1}}};
    return anchor + ELEV_BITS'($urandom_range(0, 4000)) - ELEV_BITS'(2000);
  endfunction

  // Offer one request, hold it until taken, then update the shadow state.
  task automatic send_request(input logic                 kind,
                              input logic [ROW_W-1:0]     row,
                              input logic [COL_W-1:0]     col,
                              input logic [ELEV_IN_W-1:0] elev,
                              input logic [MASK_W-1:0]    pmask);
    int unsigned gap;
    if (send_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid       <= 1'b1;
    req_bus.req_type    <= kind;
    req_bus.cell_row    <= row;
    req_bus.cell_col    <= col;
    req_bus.elevation   <= elev;
    req_bus.parent_mask <= pmask;
    do @(posedge clk_i); while (!req_bus.ready);
    requests_sent++;
    if (kind == REQ_WRITE) begin
      grid_elev_m[cell_at(row, col)]  = elev;
      grid_pmask_m[cell_at(row, col)] = pmask;
      grid_filled[cell_at(row, col)]  = 1'b1;
    end else begin
      predict_query(row, col);
    end
  endtask

  // Drop valid and hold until every owed result is back and the block is quiet.
  task automatic wait_all_results();
    req_bus.valid <= 1'b0;
    while (nbr_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the row size and then the column size register; call only while idle.
  task automatic set_grid_size(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_NUM_ROWS;
    cfg_wdata <= rows;
    @(posedge clk_i);
    cfg_idx   <= CFG_NUM_COLS;
    cfg_wdata <= cols;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    rows_in_use = (rows > MAX_ROWS) ? MAX_ROWS : int'(rows);
    cols_in_use = (cols > MAX_COLS) ? MAX_COLS : int'(cols);
  endtask

  // Fill the center and its four neighbors where needed (and now and then
  // rewrite them), then query the center. Never reads a cell left unwritten.
  task automatic visit_site(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    logic [ELEV_BITS-1:0] ctr_elev;
    logic [MASK_W-1:0]    pmask;
    int                   nr;
    int                   nc;
    if (!grid_filled[cell_at(row, col)] || $urandom_range(0, 2) == 0) begin
      ctr_elev = grid_filled[cell_at(row, col)] ? elev_near(grid_elev_m[cell_at(row, col)])
                                                : ELEV_BITS'($urandom());
      // Favor an empty parent mask so that queries find more neighbors.
      pmask = ($urandom_range(0, 1) == 0) ? '0 : MASK_W'($urandom_range(0, 15));
      send_request(REQ_WRITE, row, col, ctr_elev, pmask);
    end
    ctr_elev = grid_elev_m[cell_at(row, col)];
    for (int d = 0; d < 4; d++) begin
      nr = int'(row) + row_step[d];
      nc = int'(col) + col_step[d];
      if (!grid_filled[cell_at(nr[ROW_W-1:0], nc[COL_W-1:0])] || $urandom_range(0, 2) == 0)
        send_request(REQ_WRITE, nr[ROW_W-1:0], nc[COL_W-1:0], elev_near(ctr_elev),
                     MASK_W'($urandom_range(0, 15)));
    end
    send_request(REQ_QUERY, row, col, $urandom(), MASK_W'($urandom_range(0, 15)));
    last_row = row;
    last_col = col;
  endtask

  // Choose an interior cell, half the time next to the last one to reuse filled cells.
  task automatic visit_random_site();
    int r;
    int c;
    if ($urandom_range(0, 1) == 0) begin
      r = int'(last_row) + int'($urandom_range(0, 6)) - 3;
      c = int'(last_col) + int'($urandom_range(0, 6)) - 3;
    end else begin
      r = $urandom_range(1, rows_in_use - 2);
      c = $urandom_range(1, cols_in_use - 2);
    end
    if (r < 1) r = 1;
    if (r > rows_in_use - 2) r = rows_in_use - 2;
    if (c < 1) c = 1;
    if (c > cols_in_use - 2) c = cols_in_use - 2;
    visit_site(r[ROW_W-1:0], c[COL_W-1:0]);
  endtask

  // Query a cell on or past the grid border; these never read the grid.
  task automatic query_off_grid();
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    r = ROW_W'($urandom_range(0, MAX_ROWS - 1));
    c = COL_W'($urandom_range(0, MAX_COLS - 1));
    case ($urandom_range(0, 3))
      0:       r = '0;
      1:       r = ROW_W'($urandom_range(rows_in_use - 1, MAX_ROWS - 1));
      2:       c = '0;
      default: c = COL_W'($urandom_range(cols_in_use - 1, MAX_COLS - 1));
    endcase
    send_request(REQ_QUERY, r, c, $urandom(), MASK_W'($urandom_range(0, 15)));
  endtask

  // Extreme elevations, every parent-mask shape that matters, ties and each off-grid side.
  task automatic test_directed_cases();
    send_request(REQ_WRITE, 8'd6, 8'd5, 32'h8000_0000, 4'h0);
    send_request(REQ_WRITE, 8'd5, 8'd6, 32'h0000_0000, 4'hF);
    send_request(REQ_WRITE, 8'd4, 8'd5, 32'hFFFF_FFFF, 4'h5);
    send_request(REQ_WRITE, 8'd5, 8'd4, 32'h7FFF_FFFE, 4'hA);
    // Center at the top of the range: all four lower, widest drop to the north
    send_request(REQ_WRITE, 8'd5, 8'd5, 32'h7FFF_FFFF, 4'h0);
    send_request(REQ_QUERY, 8'd5, 8'd5, 32'h0000_0000, 4'h0);
    // Center at the bottom of the range: nothing lower
    send_request(REQ_WRITE, 8'd5, 8'd5, 32'h8000_0000, 4'h0);
    send_request(REQ_QUERY, 8'd5, 8'd5, 32'hFFFF_FFFF, 4'hF);
    // Every direction is a parent: nothing qualifies
    send_request(REQ_WRITE, 8'd5, 8'd5, 32'h7FFF_FFFF, 4'hF);
    send_request(REQ_QUERY, 8'd5, 8'd5, 32'h0000_0000, 4'h0);
    // West and east parents: north and south only
    send_request(REQ_WRITE, 8'd5, 8'd5, 32'h7FFF_FFFF, 4'hA);
    send_request(REQ_QUERY, 8'd5, 8'd5, 32'h0000_0000, 4'h0);
    // North and south parents: east and west only
    send_request(REQ_WRITE, 8'd5, 8'd5, 32'h7FFF_FFFF, 4'h5);
    send_request(REQ_QUERY, 8'd5, 8'd5, 32'h0000_0000, 4'h0);
    // Center at zero: the equal east neighbor must not count
    send_request(REQ_WRITE, 8'd5, 8'd5, 32'h0000_0000, 4'h0);
    send_request(REQ_QUERY, 8'd5, 8'd5, 32'h0000_0000, 4'h0);
    // Off-grid: south beats the rest, north beats west, then west and east alone
    send_request(REQ_QUERY, 8'd0,   8'd0,   32'h0000_0000, 4'h0);
    send_request(REQ_QUERY, 8'd255, 8'd0,   32'h0000_0000, 4'h0);
    send_request(REQ_QUERY, 8'd7,   8'd0,   32'h0000_0000, 4'h0);
    send_request(REQ_QUERY, 8'd7,   8'd255, 32'h0000_0000, 4'h0);
    send_request(REQ_WRITE, 8'd255, 8'd255, 32'h5A5A_A5A5, 4'h9);
    wait_all_results();
  endtask

  // Smallest, largest, lopsided and out-of-range grid sizes, probed at their far corner.
  task automatic test_grid_size_extremes();
    logic [CFG_W-1:0] row_set [6];
    logic [CFG_W-1:0] col_set [6];
    row_set = '{9'd3, 9'd3,   9'd256, 9'd511, 9'd4,   9'd256};
    col_set = '{9'd3, 9'd256, 9'd3,   9'd511, 9'd200, 9'd256};
    for (int k = 0; k < 6; k++) begin
      set_grid_size(row_set[k], col_set[k]);
      visit_site(ROW_W'(rows_in_use - 2), COL_W'(cols_in_use - 2));
      send_request(REQ_QUERY, ROW_W'(rows_in_use - 1), 8'd1, $urandom(), 4'h0);
      send_request(REQ_QUERY, 8'd1, COL_W'(cols_in_use - 1), $urandom(), 4'h0);
      wait_all_results();
    end
  endtask

  // Hold off the result side long enough to back the block up into its input,
  // keep offering queries meanwhile, then pause until everything has drained.
  task automatic test_result_backlog();
    rsp_hold_len = 200;
    repeat (12) visit_random_site();
    wait_all_results();
  endtask

  // Mostly well-formed fill-then-query sequences, with stray writes and
  // border queries mixed in, over several grid sizes. The last phase runs
  // without idling on either side.
  task automatic test_random_traffic();
    int unsigned stop_at;
    int unsigned pick;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 1) begin
        send_gaps_on = 1'b0;
        rsp_gaps_on  = 1'b0;
      end
      if ($urandom_range(0, 2) == 0)
        set_grid_size(CFG_W'($urandom_range(3, 511)), CFG_W'($urandom_range(3, 511)));
      else
        set_grid_size(CFG_W'($urandom_range(3, 40)), CFG_W'($urandom_range(3, 40)));
      stop_at = requests_sent + PHASE_ITEMS;
      while (requests_sent < stop_at) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)
          send_request(REQ_WRITE, ROW_W'($urandom_range(0, MAX_ROWS - 1)),
                       COL_W'($urandom_range(0, MAX_COLS - 1)), $urandom(),
                       MASK_W'($urandom_range(0, 15)));
        else if (pick == 1)
          query_off_grid();
        else
          visit_random_site();
      end
      wait_all_results();
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      bad_results++;
      $display("%0t ns: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  initial begin : clk_gen
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result-side ready: random stall bursts, plus one long hold-off on request.
  initial begin : rsp_ready_drive
    int unsigned stall;
    rsp_bus.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (rsp_hold_len != 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (rsp_hold_len) @(posedge clk_i);
        rsp_hold_len = 0;
      end else if (rsp_gaps_on && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 7);
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_bus.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Compare every accepted result against the oldest owed one.
  always @(posedge clk_i) begin : rsp_check
    rsp_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (nbr_results_q.size() == 0) begin
        bad_results++;
        $display("%0t ns: unexpected result: expected none, got status %0d row %0d col %0d",
                 $time, rsp_bus.status, rsp_bus.neighbor_row, rsp_bus.neighbor_col);
      end else begin
        want = nbr_results_q.pop_front();
        check_field("status",         want.status,         rsp_bus.status);
        check_field("neighbor_valid", want.neighbor_valid, rsp_bus.neighbor_valid);
        check_field("neighbor_row",   want.neighbor_row,   rsp_bus.neighbor_row);
        check_field("neighbor_col",   want.neighbor_col,   rsp_bus.neighbor_col);
        check_field("elevation_drop", want.elevation_drop, rsp_bus.elevation_drop);
        check_field("neighbor_total", want.neighbor_total, rsp_bus.neighbor_total);
        check_field("last",           want.last,           rsp_bus.last);
      end
    end
  end

  // Bound the run; a hang anywhere ends here.
  initial begin : cycle_watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : test_seq
    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= CFG_NUM_ROWS;
    cfg_wdata           <= '0;
    req_bus.valid       <= 1'b0;
    req_bus.req_type    <= REQ_WRITE;
    req_bus.cell_row    <= '0;
    req_bus.cell_col    <= '0;
    req_bus.elevation   <= '0;
    req_bus.parent_mask <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_grid_size_extremes();
    test_result_backlog();
    test_random_traffic();
    if (bad_results == 0 && nbr_results_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
